/* sv/hpc_pkg.sv */
// ----------------------------------------------------------------------------
// hpc_pkg
// Shared constants, types and helper functions for the haversine proximity
// classifier: CORDIC angle table, fixed-point constants, rounding shifts.
// ----------------------------------------------------------------------------
package hpc_pkg;

	localparam int CORDIC_STEPS_DEF    = 24;
	localparam int ANGLE_FRAC_BITS_DEF = 30;

	localparam int LAT_W  = 31;
	localparam int LON_W  = 32;
	localparam int DIST_W = 25;
	localparam int SAFE_W = 20;

	// internal angle and trig word
	localparam int WW = 64;

	localparam logic [63:0]  PI_Q60          = 64'h3243F6A8885A308D;
	localparam logic [63:0]  GAIN_Q60        = 64'd700114967507363222;
	localparam logic [63:0]  UNITS_HALF_TURN = 64'd1800000000;
	localparam logic [63:0]  RAD_PER_UNIT_Q62 =
		(64'd4 * PI_Q60 + UNITS_HALF_TURN / 64'd2) / UNITS_HALF_TURN;
	localparam logic [24:0]  HALF_CIRC_M     = 25'd20015087;
	localparam logic [22:0]  EARTH_RADIUS_M  = 23'd6371000;
	localparam logic [SAFE_W-1:0] SAFE_RESET = 20'd100;

	function automatic logic signed [WW-1:0] q60_to_qf(input logic [63:0] v, input int f);
		logic [63:0] r;
		int sh;
		sh = 60 - f;
		r = (v + (64'd1 << (sh - 1))) >> sh;
		return $signed(r);
	endfunction

	function automatic logic signed [WW-1:0] atan_q(input int i, input int f);
		logic [63:0] sum;
		int e;
		sum = '0;
		if (i == 0) begin
			sum = PI_Q60 >> 2;
		end else begin
			for (int k = 0; k < 61; k++) begin
				e = 60 - i * (2 * k + 1);
				if (e >= 0) begin
					if (k % 2 == 1) begin
						sum = sum - (64'd1 << e) / 64'(2 * k + 1);
					end else begin
						sum = sum + (64'd1 << e) / 64'(2 * k + 1);
					end
				end
			end
		end
		return q60_to_qf(sum, f);
	endfunction

	// round(|p| / 2^s) half up with sign, saturating at int64 limits
	function automatic logic signed [WW-1:0] rshift_round(input logic [127:0] mag,
			input logic neg, input int s);
		logic [128:0] t;
		logic [128:0] r;
		logic [63:0] o;
		t = {1'b0, mag} + (129'd1 << (s - 1));
		r = t >> s;
		if (r > 129'h7FFFFFFFFFFFFFFF) begin
			o = 64'h7FFFFFFFFFFFFFFF;
		end else begin
			o = r[63:0];
		end
		return neg ? -$signed(o) : $signed(o);
	endfunction

	typedef struct packed {
		logic [SAFE_W-1:0] safe;
	} hpc_cfg_t;

endpackage

/* sv/haversine_proximity_classifier_core.sv */
// ----------------------------------------------------------------------------
// haversine_proximity_classifier_core
// Great-circle distance of two positions and separation classification.
// ----------------------------------------------------------------------------
// Usage: an input item (lat_a, lon_a, lat_b, lon_b in degrees times 1e7) is
// taken when in_valid is high and in_stall is low. Each item gives one result
// item (distance_m, conflict, severity) on out_valid / out_stall.
// The datapath is one pipeline whose depth is set by the two CORDIC chains
// and the square-root bit stages. Throughput is one item per cycle. The whole
// pipe advances together; when out_stall is high with a valid result on the
// output, in_stall rises and every stage holds, so nothing is lost or
// repeated. safe_distance_m is written through cfg_we / cfg_wdata while
// idle: the user is bound to this, the core itself does not enforce it.
// Reset clears all valid bits and sets safe_distance_m to 100.
// ----------------------------------------------------------------------------
module haversine_proximity_classifier_core #(
	parameter int CORDIC_STEPS    = hpc_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = hpc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hpc_pkg::SAFE_W-1:0]       cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [hpc_pkg::LAT_W-1:0] lat_a,
	input  logic signed [hpc_pkg::LON_W-1:0] lon_a,
	input  logic signed [hpc_pkg::LAT_W-1:0] lat_b,
	input  logic signed [hpc_pkg::LON_W-1:0] lon_b,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [hpc_pkg::DIST_W-1:0]       distance_m,
	output logic                             conflict,
	output logic [1:0]                       severity
);
	import hpc_pkg::*;

	localparam int F = ANGLE_FRAC_BITS;
	localparam int DEPTH = 2 * (CORDIC_STEPS + 1) + (F + 2) + 12;
	localparam logic signed [63:0] ONE = 64'sd1 <<< F;
	localparam logic signed [63:0] RPU = $signed(RAD_PER_UNIT_Q62);

	logic en;
	logic [DEPTH-1:0] vld_q;
	hpc_cfg_t cfg_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cfg_q.safe <= SAFE_RESET;
		end else begin
			if (cfg_we) begin
				cfg_q.safe <= cfg_wdata;
			end
			if (en) begin
				vld_q <= {vld_q[DEPTH-2:0], in_valid};
			end
		end
	end

	// stage 1: differences
	logic signed [63:0] dlat_s1, dlon_s1, la_s1, lb_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= 64'(lat_b) - 64'(lat_a);
			dlon_s1 <= 64'(lon_b) - 64'(lon_a);
			la_s1   <= 64'(lat_a);
			lb_s1   <= 64'(lat_b);
		end
	end

	// stages 2-3: to radians
	logic signed [63:0] hlat, hlon, pa, pb;
	logic [0:0] t0, t1, t2, t3;
	hpc_mul #(.SHIFT(63 - F), .TW(1)) u_m0 (.clk, .arst_n, .en, .a(dlat_s1), .b(RPU),
		.tag_in(1'b0), .p(hlat), .tag_out(t0));
	hpc_mul #(.SHIFT(63 - F), .TW(1)) u_m1 (.clk, .arst_n, .en, .a(dlon_s1), .b(RPU),
		.tag_in(1'b0), .p(hlon), .tag_out(t1));
	hpc_mul #(.SHIFT(62 - F), .TW(1)) u_m2 (.clk, .arst_n, .en, .a(la_s1), .b(RPU),
		.tag_in(1'b0), .p(pa), .tag_out(t2));
	hpc_mul #(.SHIFT(62 - F), .TW(1)) u_m3 (.clk, .arst_n, .en, .a(lb_s1), .b(RPU),
		.tag_in(1'b0), .p(pb), .tag_out(t3));

	logic signed [63:0] s1, s2, ca, cb, d0, d1, d2, d3;
	hpc_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(F)) u_sc0 (.clk, .en,
		.z_in(hlat), .sn(s1), .cs(d0));
	hpc_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(F)) u_sc1 (.clk, .en,
		.z_in(hlon), .sn(s2), .cs(d1));
	hpc_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(F)) u_sc2 (.clk, .en,
		.z_in(pa), .sn(d2), .cs(ca));
	hpc_sincos #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(F)) u_sc3 (.clk, .en,
		.z_in(pb), .sn(d3), .cs(cb));

	// products: s1^2, ca*cb, s2^2 then (ca*cb)*(s2^2); s1^2 delayed through s1sq_s1 and s1sq_s2
	logic signed [63:0] s1sq, cacb, s2sq, prod;
	logic [0:0] t4, t5, t6, t7;
	hpc_mul #(.SHIFT(F), .TW(1)) u_m4 (.clk, .arst_n, .en, .a(s1), .b(s1),
		.tag_in(1'b0), .p(s1sq), .tag_out(t4));
	hpc_mul #(.SHIFT(F), .TW(1)) u_m5 (.clk, .arst_n, .en, .a(ca), .b(cb),
		.tag_in(1'b0), .p(cacb), .tag_out(t5));
	hpc_mul #(.SHIFT(F), .TW(1)) u_m6 (.clk, .arst_n, .en, .a(s2), .b(s2),
		.tag_in(1'b0), .p(s2sq), .tag_out(t6));
	hpc_mul #(.SHIFT(F), .TW(1)) u_m7 (.clk, .arst_n, .en, .a(cacb), .b(s2sq),
		.tag_in(1'b0), .p(prod), .tag_out(t7));

	logic signed [63:0] s1sq_s1, s1sq_s2, a_s1, a_c, oma;
	always_ff @(posedge clk) begin
		if (en) begin
			s1sq_s1 <= s1sq;
			s1sq_s2 <= s1sq_s1;
		end
	end

	always_comb begin
		a_c = s1sq_s2 + prod;
		if (a_c < 0) begin
			a_c = '0;
		end
		if (a_c > ONE) begin
			a_c = ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_c;
		end
	end
	assign oma = ONE - a_s1;

	logic signed [63:0] sa, soma, ang;
	hpc_sqrt #(.ANGLE_FRAC_BITS(F)) u_sq0 (.clk, .en, .v(a_s1), .r(sa));
	hpc_sqrt #(.ANGLE_FRAC_BITS(F)) u_sq1 (.clk, .en, .v(oma), .r(soma));
	hpc_atan #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(F)) u_at (.clk, .en,
		.x_in(soma), .y_in(sa), .z(ang));

	logic signed [63:0] dm;
	logic [0:0] t8;
	hpc_mul #(.SHIFT(F), .TW(1)) u_m8 (.clk, .arst_n, .en, .a(ang <<< 1),
		.b(64'(EARTH_RADIUS_M)), .tag_in(1'b0), .p(dm), .tag_out(t8));

	// clamp, then classify
	logic [DIST_W-1:0] dist_s1, dist_s2;
	logic              conf_s2;
	logic [1:0]        sev_s2;
	logic [DIST_W+1:0] d3x;
	logic [SAFE_W:0]   s2x;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dm < 0) begin
				dist_s1 <= '0;
			end else if (dm > 64'(HALF_CIRC_M)) begin
				dist_s1 <= HALF_CIRC_M;
			end else begin
				dist_s1 <= dm[DIST_W-1:0];
			end
		end
	end

	assign d3x = (DIST_W+2)'(dist_s1) * (DIST_W+2)'(3);
	assign s2x = {cfg_q.safe, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s2 <= dist_s1;
			conf_s2 <= (DIST_W+2)'(dist_s1) < (DIST_W+2)'(cfg_q.safe);
			if (d3x < (DIST_W+2)'(cfg_q.safe)) begin
				sev_s2 <= 2'd0;
			end else if (d3x < (DIST_W+2)'(s2x)) begin
				sev_s2 <= 2'd1;
			end else if ((DIST_W+2)'(dist_s1) < (DIST_W+2)'(cfg_q.safe)) begin
				sev_s2 <= 2'd2;
			end else begin
				sev_s2 <= 2'd3;
			end
		end
	end

	assign distance_m = dist_s2;
	assign conflict   = conf_s2;
	assign severity   = sev_s2;

	logic unused;
	assign unused = ^{t0, t1, t2, t3, t4, t5, t6, t7, t8, d0, d1, d2, d3};
endmodule

/* sv/hpc_mul.sv */
// ----------------------------------------------------------------------------
// hpc_mul
// Pipelined signed 64x64 multiply with rounding shift, four 32x32 partial
// products in one stage, summed and rounded in the next.
// ----------------------------------------------------------------------------
module hpc_mul #(
	parameter int SHIFT = 30,
	parameter int TW    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [63:0]   a,
	input  logic signed [63:0]   b,
	input  logic [TW-1:0]        tag_in,
	output logic signed [63:0]   p,
	output logic [TW-1:0]        tag_out
);
	import hpc_pkg::*;

	logic [63:0] ua, ub;
	logic [63:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic        neg_s1;
	logic [TW-1:0] tag_s1;
	logic [127:0] sum;

	assign ua = a[63] ? 64'(-a) : 64'(a);
	assign ub = b[63] ? 64'(-b) : 64'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= ua[31:0]  * ub[31:0];
			pp01_s1 <= ua[31:0]  * ub[63:32];
			pp10_s1 <= ua[63:32] * ub[31:0];
			pp11_s1 <= ua[63:32] * ub[63:32];
			neg_s1  <= a[63] ^ b[63];
			tag_s1  <= tag_in;
		end
	end

	assign sum = {64'd0, pp00_s1} + ({64'd0, pp01_s1} << 32) + ({64'd0, pp10_s1} << 32)
		+ {pp11_s1, 64'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			p       <= rshift_round(sum, neg_s1, SHIFT);
			tag_out <= tag_s1;
		end
	end

	logic unused_rst;
	assign unused_rst = arst_n;
endmodule

/* sv/hpc_sincos.sv */
// ----------------------------------------------------------------------------
// hpc_sincos
// Pipelined CORDIC rotation: range reduction then one stage per iteration.
// ----------------------------------------------------------------------------
module hpc_sincos #(
	parameter int CORDIC_STEPS    = hpc_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = hpc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  logic signed [63:0] z_in,
	output logic signed [63:0] sn,
	output logic signed [63:0] cs
);
	import hpc_pkg::*;

	localparam logic signed [63:0] PI_Q   = q60_to_qf(PI_Q60, ANGLE_FRAC_BITS);
	localparam logic signed [63:0] GAIN_Q = q60_to_qf(GAIN_Q60, ANGLE_FRAC_BITS);
	localparam logic signed [63:0] HPI    = PI_Q / 2;

	logic signed [63:0] zr, zf;
	logic               flip;
	logic signed [63:0] x_s [CORDIC_STEPS+1];
	logic signed [63:0] y_s [CORDIC_STEPS+1];
	logic signed [63:0] z_s [CORDIC_STEPS+1];
	logic               f_s [CORDIC_STEPS+1];

	// inputs stay below three half turns, so one reduction step suffices
	always_comb begin
		zr = z_in;
		if (zr > PI_Q) begin
			zr = zr - 2 * PI_Q;
		end else if (zr < -PI_Q) begin
			zr = zr + 2 * PI_Q;
		end
		flip = 1'b0;
		zf = zr;
		if (zr > HPI) begin
			zf = PI_Q - zr;
			flip = 1'b1;
		end else if (zr < -HPI) begin
			zf = -PI_Q - zr;
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GAIN_Q;
			y_s[0] <= '0;
			z_s[0] <= zf;
			f_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		localparam logic signed [63:0] AT = atan_q(i, ANGLE_FRAC_BITS);
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end
				f_s[i+1] <= f_s[i];
			end
		end
	end

	assign sn = y_s[CORDIC_STEPS];
	assign cs = f_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
endmodule

/* sv/hpc_sqrt.sv */
// ----------------------------------------------------------------------------
// hpc_sqrt
// Pipelined restoring square root, one result bit per stage:
// floor(sqrt(v * 2^F)).
// ----------------------------------------------------------------------------
module hpc_sqrt #(
	parameter int ANGLE_FRAC_BITS = hpc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  logic signed [63:0] v,
	output logic signed [63:0] r
);
	localparam int F  = ANGLE_FRAC_BITS;
	localparam int RW = F + 2;
	localparam int TW = 2 * F + 2;

	logic [TW-1:0] t_s [F+2];
	logic [RW-1:0] r_s [F+2];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s[0] <= TW'(v[F:0]) << F;
			r_s[0] <= '0;
		end
	end

	for (genvar k = 0; k <= F; k++) begin : g_bit
		localparam int B = F - k;
		logic [RW-1:0] tr;
		logic [2*RW-1:0] sq;
		assign tr = r_s[k] | (RW'(1) << B);
		assign sq = tr * tr;
		always_ff @(posedge clk) begin
			if (en) begin
				t_s[k+1] <= t_s[k];
				r_s[k+1] <= (sq <= (2*RW)'(t_s[k])) ? tr : r_s[k];
			end
		end
	end

	assign r = 64'(r_s[F+1]);
endmodule

/* sv/hpc_atan.sv */
// ----------------------------------------------------------------------------
// hpc_atan
// Pipelined CORDIC vectoring for the angle of (x, y) in the first quadrant.
// ----------------------------------------------------------------------------
module hpc_atan #(
	parameter int CORDIC_STEPS    = hpc_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = hpc_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              en,
	input  logic signed [63:0] x_in,
	input  logic signed [63:0] y_in,
	output logic signed [63:0] z
);
	import hpc_pkg::*;

	logic signed [63:0] x_s [CORDIC_STEPS+1];
	logic signed [63:0] y_s [CORDIC_STEPS+1];
	logic signed [63:0] z_s [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		localparam logic signed [63:0] AT = atan_q(i, ANGLE_FRAC_BITS);
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end
			end
		end
	end

	assign z = z_s[CORDIC_STEPS];
endmodule

/* sv/hpc_checker.sv */
// ----------------------------------------------------------------------------
// hpc_checker
// Port-level checks on the classifier core, attached by bind.
// ----------------------------------------------------------------------------
module hpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [hpc_pkg::DIST_W-1:0]       distance_m,
	input logic                             conflict,
	input logic [1:0]                       severity
);
	import hpc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance_m))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_m <= HALF_CIRC_M)
		else $error("distance beyond half circumference");

	a_sev: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (conflict == (severity != 2'd3)))
		else $error("conflict and severity disagree");

	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output stalled");
endmodule

bind haversine_proximity_classifier_core hpc_checker u_chk (.*);
